### hdl/assert_macros.svh
// shared assertion macros, clocked on clk and quiet during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property must never hold at an edge out of reset
`define ASSERT_NEVER(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);

`endif

### hdl/srll_pkg.sv
`timescale 1ns / 1ps

package srll_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CountW     = $clog2(TableDepth + 1);
  localparam int EntryCntW  = 5;

  localparam logic [1:0] OP_UPSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] ip_address;
    logic [15:0] port_number;
    logic [14:0] current_players;
    logic [14:0] max_players;
  } req_t;

  typedef struct packed {
    logic                 found;
    logic [31:0]          out_ip;
    logic [15:0]          out_port;
    logic [14:0]          out_current;
    logic [14:0]          out_max;
    logic                 table_full;
    logic [EntryCntW-1:0] entry_count;
  } rsp_t;

  // one table slot
  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [14:0] load;
    logic [14:0] cap;
  } entry_t;

  // request walking down the chain, with what it has found so far
  typedef struct packed {
    logic        valid;
    logic [1:0]  op;
    entry_t      key;
    logic        hit;
    logic        app;
    entry_t      pick;
  } tok_t;

endpackage

### hdl/srll_req_if.sv
`timescale 1ns / 1ps

interface srll_req_if;
  import srll_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/srll_rsp_if.sv
`timescale 1ns / 1ps

interface srll_rsp_if;
  import srll_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/srll_cell.sv
`timescale 1ns / 1ps

module srll_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [srll_pkg::IdxW-1:0]   idx,
  input  logic [srll_pkg::CountW-1:0] count,
  input  srll_pkg::tok_t          tok_in,
  input  srll_pkg::entry_t        nb,
  output srll_pkg::tok_t          tok_out,
  output srll_pkg::entry_t        ent
);
  import srll_pkg::*;

  tok_t   tok_next;
  entry_t ent_next;
  logic   in_use;
  logic   at_end;
  logic   key_eq;

  assign in_use = CountW'(idx) < count;
  assign at_end = CountW'(idx) == count;
  assign key_eq = (ent.ip == tok_in.key.ip) && (ent.port == tok_in.key.port);

  // act on the request as it passes this slot
  always_comb begin
    tok_next = tok_in;
    ent_next = ent;
    if (tok_in.valid) begin
      unique case (tok_in.op)
        OP_UPSERT: begin
          if (in_use && key_eq && !tok_in.hit) begin
            ent_next.load = tok_in.key.load;
            ent_next.cap  = tok_in.key.cap;
            tok_next.hit  = 1'b1;
          end else if (at_end && !tok_in.hit && !tok_in.app) begin
            ent_next     = tok_in.key;
            tok_next.app = 1'b1;
          end
        end
        OP_REMOVE: begin
          // from the match on, each slot takes its right neighbor
          if (in_use && (tok_in.hit || key_eq)) begin
            ent_next     = nb;
            tok_next.hit = 1'b1;
          end
        end
        OP_QUERY: begin
          if (in_use && (ent.load < ent.cap) &&
              (!tok_in.hit || (ent.load < tok_in.pick.load))) begin
            tok_next.pick = ent;
            tok_next.hit  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // slot contents, no reset
  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

  // hand the request on
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.op   <= tok_next.op;
    tok_out.key  <= tok_next.key;
    tok_out.hit  <= tok_next.hit;
    tok_out.app  <= tok_next.app;
    tok_out.pick <= tok_next.pick;
  end

endmodule

### hdl/server_registry_least_load_top.sv
// Least-load server registry: an ordered table of up to TableDepth servers (16), keyed by
// address and port, each holding a current load and a capacity. A word on req upserts,
// removes or queries; every word gives exactly one word on rsp. The table is a row of
// cells, one slot each; a request passes an input stage, walks the row one cell per cycle,
// then a finishing stage, and the next word is taken only once its result has moved into
// the output register, a move that waits while an earlier result is still held on rsp.
// A new word is taken while a finished result still waits on rsp. Slot contents have no
// reset; reset clears the entry count and the busy and valid flags.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module server_registry_least_load_top (
  input  logic clk,
  input  logic rst,
  srll_req_if.sink   req,
  srll_rsp_if.source rsp
);
  import srll_pkg::*;

  tok_t                head;
  tok_t                chain [TableDepth];
  entry_t              ents  [TableDepth];
  logic [CountW-1:0]   count;
  logic                busy;
  logic                done_valid;
  rsp_t                done;
  rsp_t                fin;
  logic [CountW-1:0]   count_next;
  logic                rsp_valid;
  logic                take;
  logic                land;
  tok_t                last;
  logic [TableDepth+1:0] tok_vld;
  logic                full_now;

  assign req.ready = !busy;
  assign take      = req.valid && !busy;
  assign land      = done_valid && (!rsp_valid || rsp.ready);
  assign rsp.valid = rsp_valid;
  assign last      = chain[TableDepth-1];
  assign full_now  = count == CountW'(TableDepth);

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else begin
      head.valid <= take;
    end
    if (take) begin
      head.op       <= req.data.opcode;
      head.key.ip   <= req.data.ip_address;
      head.key.port <= req.data.port_number;
      head.key.load <= req.data.current_players;
      head.key.cap  <= req.data.max_players;
      head.hit      <= 1'b0;
      head.app      <= 1'b0;
      head.pick     <= '0;
    end
  end

  // row of slots
  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    tok_t   cin;
    entry_t cnb;
    if (i == 0) begin : g_first
      assign cin = head;
    end else begin : g_mid
      assign cin = chain[i-1];
    end
    if (i == TableDepth - 1) begin : g_last
      assign cnb = '0;
    end else begin : g_inner
      assign cnb = ents[i+1];
    end
    srll_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (IdxW'(i)),
      .count   (count),
      .tok_in  (cin),
      .nb      (cnb),
      .tok_out (chain[i]),
      .ent     (ents[i])
    );
  end

  // finish the walk: new count and result word
  always_comb begin
    count_next = count;
    fin        = '0;
    unique case (last.op)
      OP_UPSERT: begin
        if (last.app) begin
          count_next = count + CountW'(1);
        end
        fin.table_full = !last.hit && !last.app;
      end
      OP_REMOVE: begin
        if (last.hit) begin
          count_next = count - CountW'(1);
        end
      end
      OP_QUERY: begin
        if (last.hit) begin
          fin.found       = 1'b1;
          fin.out_ip      = last.pick.ip;
          fin.out_port    = last.pick.port;
          fin.out_current = last.pick.load;
          fin.out_max     = last.pick.cap;
        end
      end
      default: begin
      end
    endcase
    fin.entry_count = EntryCntW'(count_next);
  end

  // control: count, busy, finishing stage, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      busy       <= 1'b0;
      done_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (take) begin
        busy <= 1'b1;
      end else if (land) begin
        busy <= 1'b0;
      end
      if (last.valid) begin
        count      <= count_next;
        done_valid <= 1'b1;
      end else if (land) begin
        done_valid <= 1'b0;
      end
      if (land) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last.valid) begin
      done <= fin;
    end
    if (land) begin
      rsp.data <= done;
    end
  end

  // every place a request can sit
  always_comb begin
    tok_vld[0]            = head.valid;
    tok_vld[TableDepth+1] = done_valid;
    for (int k = 0; k < TableDepth; k++) begin
      tok_vld[k+1] = chain[k].valid;
    end
  end

  `ASSERT_ALWAYS(a_count_range, count <= CountW'(TableDepth), "entry count above table depth")
  `ASSERT_ALWAYS(a_one_request, $onehot0(tok_vld), "more than one request in flight")
  `ASSERT_NEVER(a_idle_empty, !busy && (tok_vld != '0), "request in flight while idle")
  `ASSERT_ALWAYS(a_full_drop, done_valid && done.table_full |-> full_now, "drop with room left")

endmodule

### tb/sv/srll_reply_check.sv
`timescale 1ns / 1ps

module srll_reply_check
  import srll_pkg::*;
(
  input  logic clk,
  input  logic rst,
  srll_req_if  req,
  srll_rsp_if  rsp,
  output int   fails,
  output int   pending
);

  // shadow copy of the server table
  entry_t slot [TableDepth];
  int     used;
  rsp_t   awaited [$];
  rsp_t   want;

  // apply one request word to the shadow table and return its reply
  function automatic rsp_t serve(input req_t w);
    rsp_t        r;
    int          hit;
    int          pick;
    logic [14:0] best;
    r = '0;
    hit = -1;
    pick = -1;
    best = 15'h7fff;
    for (int i = 0; i < used; i++) begin
      if (hit < 0 && slot[i].ip == w.ip_address && slot[i].port == w.port_number) hit = i;
    end
    case (w.opcode)
      OP_UPSERT: begin
        if (hit >= 0) begin
          slot[hit].load = w.current_players;
          slot[hit].cap  = w.max_players;
        end else if (used < TableDepth) begin
          slot[used] = '{ip: w.ip_address, port: w.port_number,
                         load: w.current_players, cap: w.max_players};
          used++;
        end else begin
          r.table_full = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          // close the gap, keep insertion order
          for (int i = hit; i < used - 1; i++) slot[i] = slot[i + 1];
          used--;
        end
      end
      OP_QUERY: begin
        // strict less-than keeps the earliest entry on a tie
        for (int i = 0; i < used; i++) begin
          if (slot[i].load < slot[i].cap && slot[i].load < best) begin
            best = slot[i].load;
            pick = i;
          end
        end
        if (pick >= 0) begin
          r.found       = 1'b1;
          r.out_ip      = slot[pick].ip;
          r.out_port    = slot[pick].port;
          r.out_current = slot[pick].load;
          r.out_max     = slot[pick].cap;
        end
      end
      default: ;
    endcase
    r.entry_count = used[EntryCntW-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  // predict on each accepted request, compare on each accepted reply
  always @(posedge clk) begin
    if (rst) begin
      used = 0;
      awaited.delete();
    end else begin
      if (req.valid && req.ready) awaited = {awaited, serve(req.data)};
      if (rsp.valid && rsp.ready) begin
        if (awaited.size() == 0) begin
          $error("reply word with nothing awaited");
          fails++;
        end else begin
          want = awaited.pop_front();
          check_field("found", 32'(want.found), 32'(rsp.data.found));
          check_field("out_ip", want.out_ip, rsp.data.out_ip);
          check_field("out_port", 32'(want.out_port), 32'(rsp.data.out_port));
          check_field("out_current", 32'(want.out_current), 32'(rsp.data.out_current));
          check_field("out_max", 32'(want.out_max), 32'(rsp.data.out_max));
          check_field("table_full", 32'(want.table_full), 32'(rsp.data.table_full));
          check_field("entry_count", 32'(want.entry_count), 32'(rsp.data.entry_count));
        end
      end
    end
    pending = awaited.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import srll_pkg::*;

  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int         KeyCount   = 24;
  localparam int         CycleLimit = 1_000_000;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
  } server_key_t;

  logic clk = 1'b0;
  logic rst;
  int   fails;
  int   pending;
  int   cycles = 0;
  logic tx_quiet = 1'b0;

  server_key_t key_pool [KeyCount];

  srll_req_if req_ch ();
  srll_rsp_if rsp_ch ();

  server_registry_least_load_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  srll_reply_check watch (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .fails   (fails),
    .pending (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[server_registry_least_load_top] ERROR");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 20);
    return $urandom_range(40, 100);
  endfunction

  // loads biased toward small values, ties and the extremes
  function automatic logic [14:0] pick_load();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 15'($urandom_range(0, 7));
    if (r < 40) return 15'h0000;
    if (r < 50) return 15'h7fff;
    return 15'($urandom);
  endfunction

  // offer one word after an optional gap, return at the falling edge after accept
  task automatic offer(input logic [1:0] op, input logic [31:0] ip, input logic [15:0] port,
                       input logic [14:0] cur, input logic [14:0] cap);
    int gap;
    req_t w;
    gap = tx_quiet ? 0 : gap_len();
    w = '{opcode: op, ip_address: ip, port_number: port,
          current_players: cur, max_players: cap};
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= w;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic offer_key(input logic [1:0] op, input int k, input logic [14:0] cur,
                           input logic [14:0] cap);
    offer(op, key_pool[k].ip, key_pool[k].port, cur, cap);
  endtask

  // random word: mostly pool keys so hits, removes and a full table happen
  task automatic offer_random(input int wu, input int wr);
    int          r;
    logic [1:0]  op;
    server_key_t k;
    r = $urandom_range(99);
    if (r < wu) op = OP_UPSERT;
    else if (r < wu + wr) op = OP_REMOVE;
    else if (r < 97) op = OP_QUERY;
    else op = OP_UNKNOWN;
    if ($urandom_range(9) == 0) k = '{ip: $urandom, port: 16'($urandom)};
    else k = key_pool[$urandom_range(KeyCount - 1)];
    offer(op, k.ip, k.port, pick_load(), pick_load());
  endtask

  // reply side: random stalls, calm stretches, two long hold-offs
  function automatic int stall_len();
    if ($urandom_range(99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin : reply_side
    int cyc;
    int stall;
    rsp_ch.ready = 1'b0;
    cyc = 0;
    stall = 0;
    @(negedge clk);
    forever begin
      if (cyc == 3000 || cyc == 25000) stall = 500;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        stall--;
      end else if ((cyc / 2000) % 2 == 1) begin
        rsp_ch.ready <= 1'b1;
      end else if ($urandom_range(99) < 70) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b0;
        stall = stall_len() - 1;
      end
      cyc++;
      @(negedge clk);
    end
  end

  initial begin : word_source
    int wu;
    int wr;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rst = 1'b1;

    // key pool: extremes, shared addresses and shared ports
    key_pool[0] = '{ip: 32'h0, port: 16'h0};
    key_pool[1] = '{ip: 32'hffff_ffff, port: 16'hffff};
    for (int i = 2; i < KeyCount; i++) begin
      key_pool[i] = '{ip: $urandom, port: 16'($urandom)};
      if (i % 2 == 1) key_pool[i].ip = key_pool[i - 1].ip;
      else if (i % 4 == 0) key_pool[i].port = key_pool[i - 1].port;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words
    offer(OP_QUERY, '0, '0, '0, '0);
    offer(OP_REMOVE, '1, '1, '1, '1);
    offer(OP_UNKNOWN, '1, '1, '1, '1);
    offer_key(OP_UPSERT, 0, 15'h0, 15'h0);
    offer_key(OP_UPSERT, 1, 15'h7fff, 15'h7fff);
    offer(OP_QUERY, '0, '0, '0, '0);
    offer_key(OP_UPSERT, 2, 15'd5, 15'd10);
    offer_key(OP_UPSERT, 3, 15'd5, 15'd10);
    offer(OP_QUERY, '0, '0, '0, '0);
    offer_key(OP_UPSERT, 2, 15'd10, 15'd10);
    offer(OP_QUERY, '0, '0, '0, '0);
    offer_key(OP_UPSERT, 0, 15'h0, 15'h7fff);
    offer(OP_QUERY, '1, '1, '1, '1);
    offer_key(OP_REMOVE, 2, 15'h0, 15'h0);
    offer(OP_QUERY, '0, '0, '0, '0);
    offer_key(OP_REMOVE, 5, 15'h0, 15'h0);
    offer_key(OP_UNKNOWN, 3, 15'h0, 15'h0);
    offer_key(OP_UPSERT, 4, 15'h7ffe, 15'h7fff);
    offer_key(OP_REMOVE, 0, 15'h0, 15'h0);
    offer(OP_QUERY, '0, '0, '0, '0);
    offer_key(OP_REMOVE, 1, 15'h0, 15'h0);
    offer(OP_QUERY, '0, '0, '0, '0);

    // random phases: filling, balanced, draining and an upsert-leaning mix
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin wu = 70; wr = 10; end
        1: begin wu = 40; wr = 25; end
        2: begin wu = 15; wr = 60; end
        default: begin wu = 50; wr = 20; end
      endcase
      tx_quiet = (ph % 3 == 1);
      repeat (200) offer_random(wu, wr);
      // after every second phase, let the block drain completely before the next
      if (ph % 2 == 1) begin
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
    end

    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("[server_registry_least_load_top] OK");
    end else begin
      $display("[server_registry_least_load_top] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/srll_pkg.sv
hdl/srll_req_if.sv
hdl/srll_rsp_if.sv
hdl/srll_cell.sv
hdl/server_registry_least_load_top.sv
tb/sv/srll_reply_check.sv
tb/sv/testbench.sv
